@@ src/bisu_pkg.sv @@
// ---------------------------------------------------------------------------
// bisu_pkg
// Shared widths, the rejection threshold ROM and the result type of the
// bounded index sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package bisu_pkg;

	localparam int WORD_W    = 16;
	localparam int BOUND_W   = 8;
	localparam int COUNT_W   = 8;
	localparam int PROD_W    = WORD_W + BOUND_W;
	localparam int MAX_COUNT = 150;
	localparam int ROM_DEPTH = 2 ** BOUND_W;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_COUNT);
	localparam logic [BOUND_W-1:0] BOUND_ONE   = BOUND_W'(1);

	typedef logic [BOUND_W-1:0] thresh_rom_t [ROM_DEPTH];

	// Result of one word, passed from the datapath to the control.
	typedef struct packed {
		logic               accept;
		logic               last;
		logic [BOUND_W-1:0] slot;
		logic [BOUND_W-1:0] index;
		logic [BOUND_W-1:0] next_bound;
	} bisu_result_t;

	// 2^WORD_W mod b by restoring long division, one bit a step; b = 0 gives 0.
	function automatic thresh_rom_t gen_thresh_rom();
		thresh_rom_t        rom;
		logic [BOUND_W:0]   rem;
		logic [BOUND_W:0]   divisor;
		logic [WORD_W:0]    dividend;
		for (int b = 0; b < ROM_DEPTH; b++) begin
			rem      = '0;
			divisor  = (BOUND_W+1)'(b);
			dividend = (WORD_W+1)'(1) << WORD_W;
			if (b == 0) begin
				rom[b] = '0;
			end else begin
				for (int k = WORD_W; k >= 0; k--) begin
					rem = {rem[BOUND_W-1:0], dividend[k]};
					if (rem >= divisor) begin
						rem = rem - divisor;
					end
				end
				rom[b] = rem[BOUND_W-1:0];
			end
		end
		return rom;
	endfunction

	localparam thresh_rom_t THRESH_ROM = gen_thresh_rom();

endpackage

`default_nettype wire

@@ src/bisu_word_if.sv @@
// ---------------------------------------------------------------------------
// bisu_word_if
// Valid/ready channel carrying one random word per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface bisu_word_if;
	logic                         valid;
	logic                         ready;
	logic [bisu_pkg::WORD_W-1:0]  random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ src/bisu_index_if.sv @@
// ---------------------------------------------------------------------------
// bisu_index_if
// Valid/ready channel carrying one sampled index per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface bisu_index_if;
	logic                          valid;
	logic                          ready;
	logic [bisu_pkg::BOUND_W-1:0]  slot;
	logic [bisu_pkg::BOUND_W-1:0]  sampled_index;
	logic                          last_of_run;

	modport source (output valid, output slot, output sampled_index, output last_of_run,
		input ready);
	modport sink   (input valid, input slot, input sampled_index, input last_of_run,
		output ready);
endinterface

`default_nettype wire

@@ src/bounded_index_rejection_sampler_unit.sv @@
// ---------------------------------------------------------------------------
// bounded_index_rejection_sampler_unit
// Turns a stream of random words into runs of uniform bounded indexes by the
// nearly divisionless rejection method.
// ---------------------------------------------------------------------------
//  channel     dir  payload                                   handshake
//  word_in     in   random_word[15:0]                         valid/ready
//  index_out   out  slot[7:0], sampled_index[7:0], last_of_run  valid/ready
//  cfg         in   cfg_wdata[7:0] (index_count)              cfg_we, no ready
//
//  One word per cycle while the output is not stalled; a taken word passes the
//  input register, then multiply and ROM compare, into the result register.
//  A rejected word leaves nothing and frees its stage at once.
//  Reset sets the bound to one and index_count to 150; no clearing pass.
//  A stalled output holds the result and back-pressures the input register.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_index_rejection_sampler_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bisu_word_if.sink                          word_in,
	bisu_index_if.source                       index_out,
	input  wire logic                          cfg_we,
	input  wire logic [bisu_pkg::COUNT_W-1:0]  cfg_wdata
);

	logic [bisu_pkg::COUNT_W-1:0]  index_count_q;
	logic [bisu_pkg::BOUND_W-1:0]  bound_q;
	logic [bisu_pkg::WORD_W-1:0]   word_s1;
	logic                          valid_s1;
	logic                          out_valid_q;
	logic [bisu_pkg::BOUND_W-1:0]  slot_q;
	logic [bisu_pkg::BOUND_W-1:0]  index_q;
	logic                          last_q;
	bisu_pkg::bisu_result_t        result;
	logic                          out_free;
	logic                          advance_s1;
	logic                          emit;

	bisu_datapath u_datapath (
		.word        (word_s1),
		.bound       (bound_q),
		.index_count (index_count_q),
		.result      (result)
	);

	assign out_free      = !out_valid_q || index_out.ready;
	// a rejected word needs no room downstream
	assign advance_s1    = valid_s1 && (out_free || !result.accept);
	assign emit          = valid_s1 && result.accept && out_free;
	assign word_in.ready = !valid_s1 || advance_s1;

	assign index_out.valid         = out_valid_q;
	assign index_out.slot          = slot_q;
	assign index_out.sampled_index = index_q;
	assign index_out.last_of_run   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_count_q <= bisu_pkg::COUNT_RESET;
			bound_q       <= bisu_pkg::BOUND_ONE;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				index_count_q <= cfg_wdata;
			end
			if (word_in.ready) begin
				valid_s1 <= word_in.valid;
			end
			if (emit) begin
				bound_q     <= result.next_bound;
				out_valid_q <= 1'b1;
			end else if (index_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (word_in.valid && word_in.ready) begin
			word_s1 <= word_in.random_word;
		end
		if (emit) begin
			slot_q  <= result.slot;
			index_q <= result.index;
			last_q  <= result.last;
		end
	end

endmodule

`default_nettype wire

@@ src/bisu_datapath.sv @@
// ---------------------------------------------------------------------------
// bisu_datapath
// Multiply a word by the current bound, test the low half against the
// threshold ROM and work out the index, the last flag and the next bound.
// ---------------------------------------------------------------------------
`default_nettype none

module bisu_datapath (
	input  wire logic [bisu_pkg::WORD_W-1:0]   word,
	input  wire logic [bisu_pkg::BOUND_W-1:0]  bound,
	input  wire logic [bisu_pkg::COUNT_W-1:0]  index_count,
	output bisu_pkg::bisu_result_t             result
);

	logic [bisu_pkg::COUNT_W-1:0]  count_eff;
	logic [bisu_pkg::BOUND_W-1:0]  bound_eff;
	logic [bisu_pkg::PROD_W-1:0]   prod;
	logic [bisu_pkg::BOUND_W-1:0]  thresh;
	logic                          last;

	always_comb begin
		// zero acts as one, anything above the maximum acts as the maximum
		if (index_count == '0) begin
			count_eff = bisu_pkg::COUNT_W'(1);
		end else if (index_count > bisu_pkg::COUNT_W'(bisu_pkg::MAX_COUNT)) begin
			count_eff = bisu_pkg::COUNT_W'(bisu_pkg::MAX_COUNT);
		end else begin
			count_eff = index_count;
		end

		bound_eff = (bound == '0) ? bisu_pkg::BOUND_ONE : bound;
		prod      = bisu_pkg::PROD_W'(word) * bisu_pkg::PROD_W'(bound_eff);
		thresh    = bisu_pkg::THRESH_ROM[bound_eff];
		last      = bisu_pkg::COUNT_W'(bound_eff) >= count_eff;

		result.accept     = !(prod[bisu_pkg::WORD_W-1:0] < bisu_pkg::WORD_W'(thresh));
		result.last       = last;
		result.slot       = bound_eff - bisu_pkg::BOUND_ONE;
		result.index      = prod[bisu_pkg::PROD_W-1:bisu_pkg::WORD_W];
		result.next_bound = last ? bisu_pkg::BOUND_ONE : bound_eff + bisu_pkg::BOUND_ONE;
	end

endmodule

`default_nettype wire
